// ===== design/mtb_pkg.sv =====
// mtb_pkg: shared types and constants for the mean threshold binariser.
// Used by mtb_div, mtb_dpath, mtb_ctrl, the core top level and its checker.
`default_nettype none

package mtb_pkg;

   localparam int CFG_W      = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int PIXEL_W    = 8;
   localparam int QUOT_W     = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 2'd1;

   localparam logic [CFG_W-1:0] ROWS_RESET = 11'd512;
   localparam logic [CFG_W-1:0] COLS_RESET = 11'd512;

   localparam logic [PIXEL_W-1:0] LEVEL_LOW  = 8'd0;
   localparam logic [PIXEL_W-1:0] LEVEL_HIGH = 8'd255;

   typedef enum logic [1:0] {
      ST_ACCUM    = 2'd0,
      ST_DIVIDE   = 2'd1,
      ST_BINARIZE = 2'd2
   } mtb_state_type;

   typedef struct packed {
      logic accum_en;
      logic bin_en;
      logic div_start;
   } mtb_cmd_type;

   typedef struct packed {
      logic at_end;
      logic div_done;
      logic cfg_stale;
      logic out_full;
   } mtb_status_type;

endpackage

`default_nettype wire

// ===== design/mean_threshold_binarizer_core.sv =====
// Global mean threshold binariser, top level.
// Instantiates mtb_ctrl and mtb_dpath; depends on mtb_pkg.
//
// Usage: the same image is sent twice on req_ (valid/ready), raster order,
// rows x cols pixels per pass. Sizes are set on csr_ (index 0 rows, 1 cols);
// 0 counts as 1 and values above MAX_ROWS / MAX_COLS saturate.
// First pass: one pixel per cycle is taken, no rsp_ transaction results.
// After its last pixel the mean is formed by a restoring divider, one
// quotient bit per bit of the sum; req_ready is low while it runs.
// Second pass: one pixel per cycle, each giving one rsp_ transaction in the
// cycle after acceptance: 0 below the mean, 255 otherwise, rsp_last_pixel
// on the final pixel. The block then returns to the first pass.
// A single result register feeds rsp_; while it is held by rsp_ready low,
// second-pass input stalls. A csr_ write holds req_ready low for one cycle
// while the pixel total is recomputed. Reset: 512 x 512, first pass, sum
// and counter cleared, no result pending; req_ready stays low after reset
// is released until the registered stale flag clears.
`default_nettype none

module mean_threshold_binarizer_core #(
   parameter int MAX_ROWS = 1024,
   parameter int MAX_COLS = 1024
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [mtb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [mtb_pkg::CFG_W-1:0]       csr_wdata,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [mtb_pkg::PIXEL_W-1:0]     req_pixel_value,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [mtb_pkg::PIXEL_W-1:0]          rsp_binary_level,
   output logic                                 rsp_last_pixel
);
   import mtb_pkg::*;

   mtb_cmd_type    cmd;
   mtb_status_type sts;

   assign csr_ready = 1'b1;

   mtb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   mtb_dpath #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_pixel_value  (req_pixel_value),
      .rsp_ready        (rsp_ready),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_binary_level (rsp_binary_level),
      .rsp_last_pixel   (rsp_last_pixel)
   );

endmodule

`default_nettype wire

// ===== design/mtb_div.sv =====
// mtb_div: restoring divider, one quotient bit per cycle over the whole dividend.
// Keeps the low QUOT_W bits of the quotient. Depends on mtb_pkg.
`default_nettype none

module mtb_div #(
   parameter int DVSR_W = 20
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic [DVSR_W+mtb_pkg::QUOT_W-1:0]    dividend,
   input  wire logic [DVSR_W-1:0]                    divisor,
   output logic                                      done,
   output logic [mtb_pkg::QUOT_W-1:0]                quotient
);
   import mtb_pkg::*;

   localparam int DVD_W  = DVSR_W + QUOT_W;
   localparam int STEP_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

   logic                busy_ff, busy_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [DVSR_W-1:0]   rem_ff, rem_in;
   logic [DVD_W-1:0]    dvd_ff, dvd_in;
   logic [DVSR_W-1:0]   dvsr_ff, dvsr_in;
   logic [QUOT_W-1:0]   quot_ff, quot_in;
   logic [DVSR_W:0]     trial;
   logic [DVSR_W:0]     diff;
   logic                fits;
   logic                last_step;

   assign trial     = {rem_ff, dvd_ff[DVD_W-1]};
   assign diff      = trial - {1'b0, dvsr_ff};
   assign fits      = trial >= {1'b0, dvsr_ff};
   assign last_step = step_ff == STEP_W'(DVD_W - 1);
   assign done      = busy_ff && last_step;
   assign quotient  = quot_ff;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvsr_in = dvsr_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         dvd_in  = dividend;
         dvsr_in = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
         dvd_in  = {dvd_ff[DVD_W-2:0], 1'b0};
         quot_in = {quot_ff[QUOT_W-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (last_step) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
         quot_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         quot_ff <= quot_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      dvsr_ff <= dvsr_in;
   end

endmodule

`default_nettype wire

// ===== design/mtb_dpath.sv =====
// mtb_dpath: size registers, pixel total, running sum, pixel counter,
// threshold compare and result register. Depends on mtb_pkg and mtb_div.
`default_nettype none

module mtb_dpath #(
   parameter int MAX_ROWS = 1024,
   parameter int MAX_COLS = 1024
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   input  wire logic [mtb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [mtb_pkg::CFG_W-1:0]          csr_wdata,
   input  wire logic [mtb_pkg::PIXEL_W-1:0]        req_pixel_value,
   input  wire logic                               rsp_ready,
   input  wire mtb_pkg::mtb_cmd_type               cmd,
   output mtb_pkg::mtb_status_type                 sts,
   output logic                                    rsp_valid,
   output logic [mtb_pkg::PIXEL_W-1:0]             rsp_binary_level,
   output logic                                    rsp_last_pixel
);
   import mtb_pkg::*;

   localparam int ROW_W   = $clog2(MAX_ROWS + 1);
   localparam int COL_W   = $clog2(MAX_COLS + 1);
   localparam int TOTAL_W = ROW_W + COL_W;
   localparam int SUM_W   = TOTAL_W + QUOT_W;

   logic [CFG_W-1:0]    rows_ff, rows_in;
   logic [CFG_W-1:0]    cols_ff, cols_in;
   logic                stale_ff;
   logic [ROW_W-1:0]    rows_sat;
   logic [COL_W-1:0]    cols_sat;
   logic [TOTAL_W-1:0]  total_ff;
   logic [TOTAL_W-1:0]  ctr_ff, ctr_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SUM_W-1:0]    sum_next;
   logic                at_end;
   logic                out_valid_ff, out_valid_in;
   logic [PIXEL_W-1:0]  out_level_ff, out_level_in;
   logic                out_last_ff, out_last_in;
   logic                div_done;
   logic [QUOT_W-1:0]   mean_level;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ROWS: rows_in = csr_wdata;
            CSR_COLS: cols_in = csr_wdata;
            default:  ;
         endcase
      end
   end

   always_comb begin
      if (rows_ff == '0) begin
         rows_sat = ROW_W'(1);
      end else if (32'(rows_ff) > 32'(MAX_ROWS)) begin
         rows_sat = ROW_W'(MAX_ROWS);
      end else begin
         rows_sat = ROW_W'(rows_ff);
      end
      if (cols_ff == '0) begin
         cols_sat = COL_W'(1);
      end else if (32'(cols_ff) > 32'(MAX_COLS)) begin
         cols_sat = COL_W'(MAX_COLS);
      end else begin
         cols_sat = COL_W'(cols_ff);
      end
   end

   assign at_end   = ({1'b0, ctr_ff} + (TOTAL_W+1)'(1)) >= {1'b0, total_ff};
   assign sum_next = sum_ff + SUM_W'(req_pixel_value);

   always_comb begin
      ctr_in = ctr_ff;
      sum_in = sum_ff;
      if (cmd.accum_en || cmd.bin_en) begin
         ctr_in = at_end ? '0 : ctr_ff + TOTAL_W'(1);
      end
      if (cmd.accum_en) begin
         sum_in = at_end ? '0 : sum_next;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_level_in = out_level_ff;
      out_last_in  = out_last_ff;
      if (cmd.bin_en) begin
         out_valid_in = 1'b1;
         out_level_in = (req_pixel_value < mean_level) ? LEVEL_LOW : LEVEL_HIGH;
         out_last_in  = at_end;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   mtb_div #(
      .DVSR_W (TOTAL_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_next),
      .divisor  (total_ff),
      .done     (div_done),
      .quotient (mean_level)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff      <= ROWS_RESET;
         cols_ff      <= COLS_RESET;
         stale_ff     <= 1'b1;
         ctr_ff       <= '0;
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         stale_ff     <= csr_valid;
         ctr_ff       <= ctr_in;
         sum_ff       <= sum_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      total_ff     <= TOTAL_W'(rows_sat) * TOTAL_W'(cols_sat);
      out_level_ff <= out_level_in;
      out_last_ff  <= out_last_in;
   end

   assign sts.at_end    = at_end;
   assign sts.div_done  = div_done;
   assign sts.cfg_stale = stale_ff;
   assign sts.out_full  = out_valid_ff;

   assign rsp_valid        = out_valid_ff;
   assign rsp_binary_level = out_level_ff;
   assign rsp_last_pixel   = out_last_ff;

endmodule

`default_nettype wire

// ===== design/mtb_ctrl.sv =====
// mtb_ctrl: pass sequencer (accumulate, divide, binarise) and input handshake.
// Depends on mtb_pkg.
`default_nettype none

module mtb_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     rsp_ready,
   input  wire mtb_pkg::mtb_status_type  sts,
   output logic                          req_ready,
   output mtb_pkg::mtb_cmd_type          cmd
);
   import mtb_pkg::*;

   mtb_state_type state_ff, state_in;

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_ACCUM: begin
            req_ready     = !sts.cfg_stale;
            cmd.accum_en  = req_valid && req_ready;
            cmd.div_start = cmd.accum_en && sts.at_end;
         end
         ST_DIVIDE: begin
            req_ready = 1'b0;
         end
         ST_BINARIZE: begin
            req_ready  = !sts.cfg_stale && (!sts.out_full || rsp_ready);
            cmd.bin_en = req_valid && req_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_ACCUM: begin
            if (cmd.div_start) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (sts.div_done) begin
               state_in = ST_BINARIZE;
            end
         end
         ST_BINARIZE: begin
            if (cmd.bin_en && sts.at_end) begin
               state_in = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCUM;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/mtb_checker.sv =====
// mtb_checker: port-level assertions for mean_threshold_binarizer_core,
// attached by bind. Depends on mtb_pkg.
`default_nettype none

module mtb_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   input  wire logic                            csr_ready,
   input  wire logic [mtb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [mtb_pkg::CFG_W-1:0]       csr_wdata,
   input  wire logic                            req_valid,
   input  wire logic                            req_ready,
   input  wire logic [mtb_pkg::PIXEL_W-1:0]     req_pixel_value,
   input  wire logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   input  wire logic [mtb_pkg::PIXEL_W-1:0]     rsp_binary_level,
   input  wire logic                            rsp_last_pixel
);
   import mtb_pkg::*;

   logic unused_ports;
   assign unused_ports = ^{csr_index, csr_wdata, req_pixel_value};

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_binary_level)
                                  && $stable(rsp_last_pixel))
      else $error("result changed while stalled");

   a_level_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_binary_level == LEVEL_LOW || rsp_binary_level == LEVEL_HIGH))
      else $error("binary level neither low nor high");

   a_csr_settle: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !req_ready)
      else $error("pixel taken before total settled after register write");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("result or ready present after reset");

endmodule

bind mean_threshold_binarizer_core mtb_checker u_mtb_checker (.*);

`default_nettype wire
